// File: rtl/arss_pkg.sv
// ----------------------------------------------------------------------------
// arss_pkg: shared types and constants for the ADC range scan sequencer
// Item kinds, range codes, channel masks and the range selection function.
// ----------------------------------------------------------------------------
package arss_pkg;

	localparam int unsigned PIN_CHANNELS      = 20;
	localparam int unsigned INTERNAL_CHANNELS = 5;
	localparam int unsigned STORE_DEPTH       = PIN_CHANNELS + INTERNAL_CHANNELS;
	localparam int unsigned STORE_AW          = $clog2(STORE_DEPTH);
	localparam int unsigned MASK_W            = 29;
	localparam logic [4:0]  INT_BASE          = 5'd24;

	localparam logic [MASK_W-1:0] MASK_A   = 29'h0000_03FF;
	localparam logic [MASK_W-1:0] MASK_B   = 29'h000F_FC00;
	localparam logic [MASK_W-1:0] MASK_INT = 29'h1F00_0000;

	localparam logic [15:0] FULL_SCALE = 16'd65535;
	localparam logic [9:0]  MV_SCALE   = 10'd1000;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RNG_A   = 2'd0,
		RNG_B   = 2'd1,
		RNG_INT = 2'd2,
		RNG_BAD = 2'd3
	} rng_t;

	typedef enum logic {
		REG_MASK   = 1'b0,
		REG_PERIOD = 1'b1
	} reg_idx_t;

	// Range choice plus scan bounds
	typedef struct packed {
		rng_t       rng;
		logic [4:0] lo;
		logic [4:0] hi;
	} scan_sel_t;

	// Status that rides along with an item through the pipe
	typedef struct packed {
		logic       running;
		logic       enabled;
		logic [4:0] channel;
		rng_t       rng;
		logic       done;
	} status_t;

	function automatic logic [MASK_W-1:0] rng_mask(input rng_t r);
		logic [MASK_W-1:0] m;
		unique case (r)
			RNG_A:   m = MASK_A;
			RNG_B:   m = MASK_B;
			default: m = MASK_INT;
		endcase
		return m;
	endfunction

	function automatic rng_t rng_succ(input rng_t r);
		rng_t n;
		unique case (r)
			RNG_A:   n = RNG_B;
			RNG_B:   n = RNG_INT;
			RNG_INT: n = RNG_A;
			default: n = RNG_B;
		endcase
		return n;
	endfunction

	// Round-robin pick of the next range that has enabled channels; keep the
	// current one when none has. Bounds are the lowest and highest set bits.
	function automatic scan_sel_t pick_range(input rng_t cur, input logic [MASK_W-1:0] mask);
		scan_sel_t         s;
		rng_t              c;
		logic              found;
		logic [MASK_W-1:0] m;
		c     = cur;
		found = 1'b0;
		s.rng = cur;
		for (int k = 0; k < 3; k++) begin
			c = rng_succ(c);
			if (!found && (|(mask & rng_mask(c)))) begin
				s.rng = c;
				found = 1'b1;
			end
		end
		m    = mask & rng_mask(s.rng);
		s.lo = 5'd0;
		s.hi = 5'd0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) s.lo = 5'(i);
		end
		for (int i = 0; i < MASK_W; i++) begin
			if (m[i]) s.hi = 5'(i);
		end
		return s;
	endfunction

endpackage

// File: rtl/adc_range_scan_sequencer_core.sv
// ----------------------------------------------------------------------------
// adc_range_scan_sequencer_core
// Range scan sequencer with a 25-entry sample store and millivolt readout.
// ----------------------------------------------------------------------------
// Pipeline: input accept, then the store read, scale multiply and reciprocal
//   correction registers to result valid; an output stall holds them.
// Throughput: one item per cycle; the whole pipe holds when the output
//   register is full and not taken, set by the single output register.
// Reset: asynchronous, clears control state and the store valid bits, so
//   every store entry reads as zero until a sample is written to it.
module adc_range_scan_sequencer_core (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_write,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data,
	// input items
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic [31:0]             time_ms,
	input  logic [15:0]             sample,
	input  logic [4:0]              read_channel,
	// result items
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    converting,
	output logic                    adc_enabled,
	output logic [4:0]              scan_channel,
	output logic [1:0]              scan_range,
	output logic                    sweep_done,
	output logic [15:0]             read_value,
	output logic [9:0]              read_millivolts
);
	import arss_pkg::*;

	// ------------------------------------------------------------------
	// Configuration and control state
	// ------------------------------------------------------------------
	logic [MASK_W-1:0] mask_q;
	logic [31:0]       period_q;
	rng_t              rng_q;
	logic [4:0]        next_q;
	logic [4:0]        last_q;
	logic              running_q;
	logic              enabled_q;
	logic [31:0]       sweep_t_q;

	logic en;        // pipe advance
	logic accept;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Next control state for the accepted item
	// ------------------------------------------------------------------
	logic              used;
	logic [MASK_W-1:0] mask_w;
	scan_sel_t         sel_end;     // choice made when a range runs out
	scan_sel_t         sel_cfg;     // choice made on a mask write
	logic [4:0]        nc;
	rng_t              rng_d;
	logic [4:0]        next_d;
	logic [4:0]        last_d;
	logic              running_d;
	logic              enabled_d;
	logic [31:0]       sweep_t_d;
	logic              done_d;
	logic              cont;

	// Store address for a sample write
	logic                wr_hit;
	logic [STORE_AW-1:0] wr_idx;
	logic                do_write;
	// Store address for a read
	logic                rd_hit;
	logic [STORE_AW-1:0] rd_idx;

	assign used    = |(mask_q & (MASK_A | MASK_B | MASK_INT));
	assign mask_w  = cfg_data[MASK_W-1:0];
	assign sel_cfg = pick_range(RNG_A, mask_w);
	assign sel_end = pick_range(rng_q, mask_q);
	assign nc      = next_q + 5'd1;
	assign cont    = ((sel_end.rng == RNG_B) && (|(mask_q & MASK_A))) ||
	                 ((sel_end.rng == RNG_INT) && (|(mask_q & (MASK_A | MASK_B))));

	always_comb begin
		rng_d     = rng_q;
		next_d    = next_q;
		last_d    = last_q;
		running_d = running_q;
		enabled_d = enabled_q;
		sweep_t_d = sweep_t_q;
		done_d    = 1'b0;
		do_write  = 1'b0;
		case (kind_t'(kind))
			KIND_TICK: begin
				// start a sweep once the period has fully passed
				if (used && ((time_ms - sweep_t_q) > period_q)) begin
					enabled_d = 1'b1;
					running_d = 1'b1;
					sweep_t_d = time_ms;
				end
			end
			KIND_SAMPLE: begin
				if (running_q) begin
					do_write = wr_hit;
					if (nc > last_q) begin
						// range exhausted: move on, or close the sweep
						rng_d  = sel_end.rng;
						next_d = sel_end.lo;
						last_d = sel_end.hi;
						if (cont) begin
							running_d = 1'b1;
						end else begin
							done_d    = 1'b1;
							sweep_t_d = time_ms;
							running_d = (period_q == 32'd0);
							if (period_q != 32'd0) enabled_d = 1'b0;
						end
					end else begin
						next_d = nc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			period_q  <= '0;
			rng_q     <= RNG_A;
			next_q    <= '0;
			last_q    <= '0;
			running_q <= 1'b0;
			enabled_q <= 1'b0;
			sweep_t_q <= '0;
		end else if (cfg_write) begin
			// the user must make configuration arrive only while the block is idle; the block does not enforce this
			if (reg_idx_t'(cfg_index) == REG_MASK) begin
				mask_q    <= mask_w;
				running_q <= 1'b0;
				enabled_q <= 1'b0;
				rng_q     <= sel_cfg.rng;
				next_q    <= sel_cfg.lo;
				last_q    <= sel_cfg.hi;
			end else begin
				period_q <= cfg_data;
			end
		end else if (accept) begin
			rng_q     <= rng_d;
			next_q    <= next_d;
			last_q    <= last_d;
			running_q <= running_d;
			enabled_q <= enabled_d;
			sweep_t_q <= sweep_t_d;
		end
	end

	// ------------------------------------------------------------------
	// Channel to store slot: pins map straight, internal channels follow
	// ------------------------------------------------------------------
	always_comb begin
		wr_hit = 1'b0;
		wr_idx = '0;
		if (next_q < 5'(PIN_CHANNELS)) begin
			wr_hit = 1'b1;
			wr_idx = STORE_AW'(next_q);
		end else if ((next_q >= INT_BASE) && (next_q < INT_BASE + 5'(INTERNAL_CHANNELS))) begin
			wr_hit = 1'b1;
			wr_idx = STORE_AW'(next_q - INT_BASE + 5'(PIN_CHANNELS));
		end
	end

	always_comb begin
		rd_hit = 1'b0;
		rd_idx = '0;
		if (kind_t'(kind) == KIND_READ) begin
			if (read_channel < 5'(PIN_CHANNELS)) begin
				rd_hit = 1'b1;
				rd_idx = STORE_AW'(read_channel);
			end else if ((read_channel >= INT_BASE) &&
			             (read_channel < INT_BASE + 5'(INTERNAL_CHANNELS))) begin
				rd_hit = 1'b1;
				rd_idx = STORE_AW'(read_channel - INT_BASE + 5'(PIN_CHANNELS));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample store: one write and one registered read per cycle. Writes
	// land at the accept edge, so a read item in any later cycle already
	// sees them; no forwarding path is needed. Valid bits stand in for
	// clearing the array at reset.
	// ------------------------------------------------------------------
	logic [15:0]            store_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] slot_vld_q;

	always_ff @(posedge clk) begin
		if (accept && do_write) store_mem[wr_idx] <= sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (accept && do_write) begin
			slot_vld_q[wr_idx] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: store read data
	// ------------------------------------------------------------------
	logic        v_s1;
	status_t     stat_s1;
	logic        hit_s1;
	logic [15:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1 <= store_mem[rd_idx];
			hit_s1   <= rd_hit && slot_vld_q[rd_idx];
			stat_s1  <= '{running: running_d, enabled: enabled_d, channel: next_d,
			              rng: rng_d, done: done_d};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale by 1000
	// ------------------------------------------------------------------
	logic        v_s2;
	status_t     stat_s2;
	logic [15:0] rv_s2;
	logic [25:0] prod_s2;
	logic [15:0] rv_s1;

	assign rv_s1 = hit_s1 ? rdata_s1 : 16'd0;

	always_ff @(posedge clk) begin
		if (en) begin
			stat_s2 <= stat_s1;
			rv_s2   <= rv_s1;
			prod_s2 <= 26'(rv_s1) * 26'(MV_SCALE);
		end
	end

	// ------------------------------------------------------------------
	// Output register: divide by 65535 as a shift plus one correction,
	// since x = q*65536 + r = q*65535 + (q + r), with q + r below twice 65535.
	// ------------------------------------------------------------------
	logic [9:0]  q_est;
	logic [16:0] rem_est;
	logic [9:0]  mv_s2;
	status_t     stat_q;
	logic [15:0] rv_q;
	logic [9:0]  mv_q;

	assign q_est   = prod_s2[25:16];
	assign rem_est = 17'(prod_s2[15:0]) + 17'(q_est);
	assign mv_s2   = q_est + 10'(rem_est >= 17'(FULL_SCALE));

	always_ff @(posedge clk) begin
		if (en) begin
			stat_q <= stat_s2;
			rv_q   <= rv_s2;
			mv_q   <= mv_s2;
		end
	end

	// item valid flags along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= accept;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	assign converting      = stat_q.running;
	assign adc_enabled     = stat_q.enabled;
	assign scan_channel    = stat_q.channel;
	assign scan_range      = stat_q.rng;
	assign sweep_done      = stat_q.done;
	assign read_value      = rv_q;
	assign read_millivolts = mv_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_run_needs_adc: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> enabled_q)
		else $error("scan running with converter off");

	a_chan_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (next_q <= last_q))
		else $error("scan channel past range end");

	a_idle_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!used |-> !running_q)
		else $error("scan running with empty mask");

	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_millivolts <= MV_SCALE))
		else $error("millivolts above full scale");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sweep_done && !converting) |-> !adc_enabled)
		else $error("sweep ended without stopping converter");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for adc_range_scan_sequencer_core
// Drives tick, sample, read and no-op items through the valid/ready input
// channel, checks every result item against a cycle-free model of the range
// scan sequencer or, for typed rows, the table's value. A short directed table
// comes first, then random sweeps under register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import arss_pkg::*;

	// Cycles with no item moving on either channel before the run is aborted
	localparam int unsigned STALL_LIMIT   = 2000;
	// Items per register setting in the random part
	localparam int unsigned SEGMENT_ITEMS = 80;
	localparam int unsigned MAX_GAP       = 30;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] time_ms;
		logic [15:0] sample;
		logic [4:0]  chan;
	} scan_item_t;

	typedef struct packed {
		logic        conv;
		logic        adc_en;
		logic [4:0]  chan;
		rng_t        rng;
		logic        done;
		logic [15:0] value;
		logic [9:0]  mv;
	} sweep_status_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_SETUP
	} row_kind_t;

	typedef struct {
		row_kind_t     what;
		scan_item_t    item;
		logic [28:0]   mask;
		logic [31:0]   period;
		bit            typed;
		sweep_status_t want;
	} plan_row_t;

	// DUT-facing signals; the driven ones are known from time zero
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	reg_idx_t    cfg_index    = REG_MASK;
	logic [31:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	kind_t       item_kind    = KIND_NOP;
	logic [31:0] item_time    = '0;
	logic [15:0] item_sample  = '0;
	logic [4:0]  item_channel = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic        converting;
	logic        adc_enabled;
	logic [4:0]  scan_channel;
	logic [1:0]  scan_range;
	logic        sweep_done;
	logic [15:0] read_value;
	logic [9:0]  read_millivolts;

	// Sequencer model: registers and state
	logic [28:0] seq_mask;
	logic [31:0] seq_period;
	rng_t        seq_range;
	logic [4:0]  seq_next;
	logic [4:0]  seq_last;
	logic        seq_running;
	logic        seq_enabled;
	logic [31:0] seq_last_sweep;
	logic [15:0] seq_store [STORE_DEPTH];

	// Status items predicted for accepted inputs, oldest first
	sweep_status_t pending_status_q[$];

	int send_idle_pct   = 0;
	int stall_pct       = 0;
	int mismatch_count  = 0;
	int results_checked = 0;
	int items_sent      = 0;
	int settings_loaded = 0;
	int sweeps_seen     = 0;
	logic [31:0] tb_time = '0;

	adc_range_scan_sequencer_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (item_kind),
		.time_ms         (item_time),
		.sample          (item_sample),
		.read_channel    (item_channel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.converting      (converting),
		.adc_enabled     (adc_enabled),
		.scan_channel    (scan_channel),
		.scan_range      (scan_range),
		.sweep_done      (sweep_done),
		.read_value      (read_value),
		.read_millivolts (read_millivolts)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------
	function automatic logic [28:0] range_bits(input rng_t r);
		case (r)
			RNG_A:   return MASK_A;
			RNG_B:   return MASK_B;
			default: return MASK_INT;
		endcase
	endfunction

	function automatic logic [4:0] lowest_bit(input logic [28:0] m);
		logic [4:0] lo;
		lo = '0;
		for (int i = 28; i >= 0; i--) begin
			if (m[i]) lo = 5'(i);
		end
		return lo;
	endfunction

	function automatic logic [4:0] highest_bit(input logic [28:0] m);
		logic [4:0] hi;
		hi = '0;
		for (int i = 0; i < 29; i++) begin
			if (m[i]) hi = 5'(i);
		end
		return hi;
	endfunction

	// Store slot of a channel; -1 for channels 20-23 and 29-31
	function automatic int slot_of(input logic [4:0] ch);
		if (ch < PIN_CHANNELS) return int'(ch);
		if (ch >= INT_BASE && ch < INT_BASE + INTERNAL_CHANNELS)
			return PIN_CHANNELS + int'(ch - INT_BASE);
		return -1;
	endfunction

	// Step round-robin to the next range with enabled channels, keep the
	// current one when none has any, and load the scan bounds.
	task automatic pick_next_range();
		logic [28:0] bits;
		rng_t        pick;
		bit          found;
		pick  = seq_range;
		found = 1'b0;
		for (int k = 1; k <= 3; k++) begin
			rng_t cand;
			cand = rng_t'((int'(seq_range) + k) % 3);
			if (!found && (|(seq_mask & range_bits(cand)))) begin
				pick  = cand;
				found = 1'b1;
			end
		end
		seq_range = pick;
		bits      = seq_mask & range_bits(pick);
		seq_next  = lowest_bit(bits);
		seq_last  = highest_bit(bits);
	endtask

	// A mask write stops the scan and restarts range choice after range A
	task automatic model_mask_write(input logic [28:0] mask);
		seq_mask    = mask;
		seq_running = 1'b0;
		seq_enabled = 1'b0;
		seq_range   = RNG_A;
		pick_next_range();
	endtask

	task automatic advance_sequencer(input scan_item_t it, output sweep_status_t st);
		int          slot;
		logic        done;
		logic [15:0] rv;
		logic [31:0] elapsed;
		logic [31:0] scaled;
		done    = 1'b0;
		rv      = '0;
		elapsed = it.time_ms - seq_last_sweep;
		case (it.kind)
			KIND_TICK: begin
				// Start (or re-arm the timer of) a sweep once the period has passed
				if ((|(seq_mask & (MASK_A | MASK_B | MASK_INT))) && elapsed > seq_period) begin
					seq_enabled    = 1'b1;
					seq_last_sweep = it.time_ms;
					seq_running    = 1'b1;
				end
			end
			KIND_SAMPLE: begin
				if (seq_running) begin
					slot = slot_of(seq_next);
					if (slot >= 0) seq_store[slot] = it.sample;
					seq_next = seq_next + 5'd1;
					if (seq_next > seq_last) begin
						seq_running = 1'b0;
						pick_next_range();
						// Keep going while the new range still lies inside this sweep
						if ((seq_range == RNG_B && (|(seq_mask & MASK_A))) ||
								(seq_range == RNG_INT && (|(seq_mask & (MASK_A | MASK_B))))) begin
							seq_running = 1'b1;
						end else begin
							done           = 1'b1;
							seq_last_sweep = it.time_ms;
							if (seq_period == '0) seq_running = 1'b1;
							else seq_enabled = 1'b0;
						end
					end
				end
			end
			KIND_READ: begin
				slot = slot_of(it.chan);
				if (slot >= 0) rv = seq_store[slot];
			end
			default: ;
		endcase
		scaled = ({16'b0, rv} * 32'(MV_SCALE)) / 32'(FULL_SCALE);
		st = '{seq_running, seq_enabled, seq_next, seq_range, done, rv, scaled[9:0]};
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Hold off for a random gap, present the item, wait for the handshake,
	// then queue what the model (or a typed row) says must come back.
	task automatic issue_item(input scan_item_t it, input bit typed, input sweep_status_t want);
		int            gap;
		sweep_status_t pred;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		item_kind    <= it.kind;
		item_time    <= it.time_ms;
		item_sample  <= it.sample;
		item_channel <= it.chan;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_sequencer(it, pred);
		pending_status_q.push_back(typed ? want : pred);
		if (pred.done) sweeps_seen++;
		items_sent++;
	endtask

	// Drain the block, then write the mask and the period on back-to-back edges
	task automatic load_settings(input logic [28:0] mask, input logic [31:0] period);
		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_MASK;
		cfg_data  <= {3'($urandom), mask};
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_write <= 1'b0;
		model_mask_write(mask);
		seq_period = period;
		settings_loaded++;
	endtask

	function automatic sweep_status_t idle_status(input logic [4:0] ch, input rng_t r,
			input logic [15:0] v, input logic [9:0] mv);
		return '{1'b0, 1'b0, ch, r, 1'b0, v, mv};
	endfunction

	function automatic plan_row_t plan_item(input kind_t k, input logic [31:0] t,
			input logic [15:0] smp, input logic [4:0] ch, input bit typed = 1'b0,
			input sweep_status_t want = '0);
		plan_row_t r;
		r.what   = ROW_ITEM;
		r.item   = '{k, t, smp, ch};
		r.mask   = '0;
		r.period = '0;
		r.typed  = typed;
		r.want   = want;
		return r;
	endfunction

	function automatic plan_row_t plan_setup(input logic [28:0] mask, input logic [31:0] period);
		plan_row_t r;
		r        = plan_item(KIND_NOP, '0, '0, '0);
		r.what   = ROW_SETUP;
		r.mask   = mask;
		r.period = period;
		return r;
	endfunction

	task automatic show_status(input string tag, input sweep_status_t s);
		$display("%s conv=%0b en=%0b ch=%0d rng=%0d done=%0b value=%h mv=%0d",
			tag, s.conv, s.adc_en, s.chan, s.rng, s.done, s.value, s.mv);
	endtask

	// ------------------------------------------------------------------
	// Result checker and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sweep_status_t got;
		sweep_status_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{converting, adc_enabled, scan_channel, rng_t'(scan_range), sweep_done,
				read_value, read_millivolts};
			results_checked++;
			if (pending_status_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) show_status("unexpected result item:", got);
			end else begin
				want = pending_status_q.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at %0t ns", $realtime);
						show_status("  expected:", want);
						show_status("  actual:  ", got);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Abort when nothing moves on either channel for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
		$display("** adc_range_scan_sequencer_core: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		plan_row_t   plan[$];
		scan_item_t  it;
		logic [28:0] mask;
		logic [31:0] period;
		int          counted;
		int          pick;
		bit          was_running;
		int          phase_send  [4];
		int          phase_stall [4];

		// No idling, sender idle, receiver stalling, both lightly
		phase_send  = '{0, 83, 0, 17};
		phase_stall = '{0, 0, 83, 17};

		seq_mask       = '0;
		seq_period     = '0;
		seq_last_sweep = '0;
		foreach (seq_store[i]) seq_store[i] = '0;
		model_mask_write('0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty mask after reset: range A, channel 0, nothing starts
		plan.push_back(plan_item(KIND_NOP, 32'h0, 16'h0, 5'd0, 1, idle_status(0, RNG_A, 0, 0)));
		plan.push_back(plan_item(KIND_TICK, 32'hFFFF_FFFF, 16'h0, 5'd0, 1,
			idle_status(0, RNG_A, 0, 0)));
		plan.push_back(plan_item(KIND_SAMPLE, 32'h0, 16'hFFFF, 5'd0, 1,
			idle_status(0, RNG_A, 0, 0)));
		plan.push_back(plan_item(KIND_READ, 32'h0, 16'h0, 5'd31, 1, idle_status(0, RNG_A, 0, 0)));
		// One channel per range plus a dead bit at 20: first range is B
		plan.push_back(plan_setup(29'h1010_0600, 32'd0));
		plan.push_back(plan_item(KIND_NOP, 32'h0, 16'h0, 5'd0, 1, idle_status(10, RNG_B, 0, 0)));
		plan.push_back(plan_item(KIND_TICK, 32'd0, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_TICK, 32'd1, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_SAMPLE, 32'd2, 16'hFFFF, 5'd0));
		plan.push_back(plan_item(KIND_TICK, 32'd3, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_SAMPLE, 32'd4, 16'h8000, 5'd0));
		plan.push_back(plan_item(KIND_SAMPLE, 32'd5, 16'h0000, 5'd0));
		// Stop everything, then read back the store
		plan.push_back(plan_setup(29'h0, 32'd0));
		plan.push_back(plan_item(KIND_READ, 32'h0, 16'h0, 5'd10, 1,
			idle_status(0, RNG_A, 16'hFFFF, 10'd1000)));
		plan.push_back(plan_item(KIND_READ, 32'h0, 16'h0, 5'd20, 1, idle_status(0, RNG_A, 0, 0)));
		plan.push_back(plan_item(KIND_READ, 32'h0, 16'h0, 5'd28));
		plan.push_back(plan_item(KIND_READ, 32'h0, 16'h0, 5'd29, 1, idle_status(0, RNG_A, 0, 0)));
		// Longest period: no tick can ever pass it
		plan.push_back(plan_setup(29'h1FFF_FFFF, 32'hFFFF_FFFF));
		plan.push_back(plan_item(KIND_TICK, 32'hFFFF_FFFF, 16'h0, 5'd0));
		// Wrapped time, timer re-armed while running, no-op kind
		plan.push_back(plan_setup(29'h1FFF_FFFF, 32'd100));
		plan.push_back(plan_item(KIND_TICK, 32'hFFFF_FFF0, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_SAMPLE, 32'hFFFF_FFF8, 16'h5A5A, 5'd0));
		plan.push_back(plan_item(KIND_TICK, 32'h0000_0050, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_TICK, 32'h0000_0060, 16'h0, 5'd0));
		plan.push_back(plan_item(KIND_NOP, 32'hA5A5_A5A5, 16'hFFFF, 5'd31));
		plan.push_back(plan_item(KIND_SAMPLE, 32'h0000_0061, 16'hA5A5, 5'd0));

		send_idle_pct = 17;
		stall_pct     = 17;
		foreach (plan[i]) begin
			if (plan[i].what == ROW_SETUP) load_settings(plan[i].mask, plan[i].period);
			else issue_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		// Random sweeps: four idling patterns, four register settings each
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send[p];
			stall_pct     = phase_stall[p];
			for (int s = 0; s < 4; s++) begin
				case ($urandom_range(7))
					0:       mask = '0;
					1:       mask = '1;
					2:       mask = 29'($urandom);
					default: begin
						// Sparse masks keep sweeps short
						mask = '0;
						repeat ($urandom_range(1, 3)) mask[$urandom_range(28)] = 1'b1;
					end
				endcase
				case ($urandom_range(7))
					0, 1:    period = '0;
					2:       period = '1;
					3:       period = $urandom;
					default: period = $urandom_range(1, 30);
				endcase
				load_settings(mask, period);

				counted = 0;
				while (counted < SEGMENT_ITEMS) begin
					was_running = seq_running;
					pick        = $urandom_range(99);
					it.sample   = 16'($urandom);
					if ($urandom_range(15) == 0) it.sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					it.chan = 5'($urandom_range(31));
					// Mostly samples while a scan runs, mostly ticks while idle
					if (was_running) begin
						if (pick < 70) it.kind = KIND_SAMPLE;
						else if (pick < 80) it.kind = KIND_TICK;
						else if (pick < 96) it.kind = KIND_READ;
						else it.kind = KIND_NOP;
					end else begin
						if (pick < 50) it.kind = KIND_TICK;
						else if (pick < 62) it.kind = KIND_SAMPLE;
						else if (pick < 92) it.kind = KIND_READ;
						else it.kind = KIND_NOP;
					end
					case (it.kind)
						KIND_TICK: begin
							if ($urandom_range(19) == 0) tb_time = $urandom;
							else tb_time = tb_time + $urandom_range(40);
							it.time_ms = tb_time;
						end
						KIND_SAMPLE: begin
							tb_time    = tb_time + $urandom_range(3);
							it.time_ms = tb_time;
						end
						default: it.time_ms = $urandom;
					endcase
					issue_item(it, 1'b0, '0);
					// Samples dropped by an idle block do not count
					if (!(it.kind == KIND_SAMPLE && !was_running)) counted++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) @(posedge clk);
		// Leave room for any stray result item to show up
		repeat (8) @(posedge clk);

		$display("checked %0d result items for %0d input items over %0d register settings",
			results_checked, items_sent, settings_loaded);
		$display("%0d sweeps completed, %0d mismatches", sweeps_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("** adc_range_scan_sequencer_core: PASSED **");
		end else begin
			$display("** adc_range_scan_sequencer_core: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/arss_pkg.sv
rtl/adc_range_scan_sequencer_core.sv
bench/tb.sv
